FILE: hw/rtl/orte_pkg.sv
package orte_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PEER_SLOTS    = 16;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int DL_W    = $clog2(PEER_SLOTS + 1);
  localparam int PEER_W  = 4;
  localparam int KEY_W   = 64;
  localparam int TIME_W  = 63;
  localparam int SPACE_W = 12;
  localparam int STALL_W = 26;
  localparam int CFG_W   = 26;

  // half a second in microseconds
  localparam int HALF_SEC_W = 19;
  localparam logic [HALF_SEC_W-1:0] HALF_SEC_US = HALF_SEC_W'(500000);
  localparam int MUL1_W = SPACE_W + HALF_SEC_W;
  localparam int MUL2_W = MUL1_W + DL_W + 1;

  localparam logic CFG_SPACING = 1'b0;
  localparam logic CFG_STALL   = 1'b1;

  typedef enum logic [2:0] {
    OP_REQUEST    = 3'd0,
    OP_FORGET_REQ = 3'd1,
    OP_FORGET_SUP = 3'd2,
    OP_MARK_STALL = 3'd3,
    OP_CHECK      = 3'd4,
    OP_LOOKUP     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SAME      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_FIND,
    S_DISP,
    S_FGT1,
    S_FGT2,
    S_INS,
    S_SUP1,
    S_SUP2,
    S_CHK1,
    S_CHK2,
    S_CHK3,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              del;
    logic [IDX_W-1:0]  del_idx;
    logic              ins;
    logic [IDX_W-1:0]  ins_idx;
    logic [KEY_W-1:0]  ins_key;
    logic [PEER_W-1:0] ins_owner;
    logic [KEY_W-1:0]  cmp_key;
    logic [PEER_W-1:0] cmp_owner;
  } chain_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

FILE: hw/rtl/orte_cell.sv
module orte_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [orte_pkg::IDX_W-1:0]    cell_idx_i,
  input  orte_pkg::chain_ctl_t          ctl_i,
  input  logic                          nxt_valid_i,
  input  logic [orte_pkg::KEY_W-1:0]    nxt_key_i,
  input  logic [orte_pkg::PEER_W-1:0]   nxt_owner_i,
  output logic                          valid_o,
  output logic [orte_pkg::KEY_W-1:0]    key_o,
  output logic [orte_pkg::PEER_W-1:0]   owner_o,
  output logic                          key_hit_o,
  output logic                          own_hit_o
);

  logic                        valid_q;
  logic [orte_pkg::KEY_W-1:0]  key_q;
  logic [orte_pkg::PEER_W-1:0] owner_q;
  logic                        shift;
  logic                        load;

  // cells at and above a deleted slot take their upper neighbor
  assign shift = ctl_i.del && (cell_idx_i >= ctl_i.del_idx);
  assign load  = ctl_i.ins && (cell_idx_i == ctl_i.ins_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= nxt_valid_i;
    end else if (load) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q   <= nxt_key_i;
      owner_q <= nxt_owner_i;
    end else if (load) begin
      key_q   <= ctl_i.ins_key;
      owner_q <= ctl_i.ins_owner;
    end
  end

  assign valid_o   = valid_q;
  assign key_o     = key_q;
  assign owner_o   = owner_q;
  assign key_hit_o = valid_q && (key_q == ctl_i.cmp_key);
  assign own_hit_o = valid_q && (owner_q == ctl_i.cmp_owner);

endmodule

FILE: hw/rtl/orte_pick.sv
module orte_pick (
  input  logic [orte_pkg::TABLE_ENTRIES-1:0] vec_i,
  output orte_pkg::pick_t                    pick_o
);

  always_comb begin
    pick_o.found = |vec_i;
    pick_o.idx   = '0;
    for (int i = orte_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        pick_o.idx = orte_pkg::IDX_W'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/orte_chain.sv
module orte_chain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  orte_pkg::chain_ctl_t               ctl_i,
  input  logic [orte_pkg::IDX_W-1:0]         rd_idx_i,
  output logic [orte_pkg::TABLE_ENTRIES-1:0] key_hit_o,
  output logic [orte_pkg::TABLE_ENTRIES-1:0] own_hit_o,
  output logic [orte_pkg::KEY_W-1:0]         rd_key_o,
  output logic [orte_pkg::PEER_W-1:0]        rd_owner_o
);

  localparam int N = orte_pkg::TABLE_ENTRIES;

  logic                        valid_w [N+1];
  logic [orte_pkg::KEY_W-1:0]  key_w   [N+1];
  logic [orte_pkg::PEER_W-1:0] owner_w [N+1];

  // empty entry above the top cell
  assign valid_w[N] = 1'b0;
  assign key_w[N]   = '0;
  assign owner_w[N] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    orte_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (orte_pkg::IDX_W'(g)),
      .ctl_i       (ctl_i),
      .nxt_valid_i (valid_w[g+1]),
      .nxt_key_i   (key_w[g+1]),
      .nxt_owner_i (owner_w[g+1]),
      .valid_o     (valid_w[g]),
      .key_o       (key_w[g]),
      .owner_o     (owner_w[g]),
      .key_hit_o   (key_hit_o[g]),
      .own_hit_o   (own_hit_o[g])
    );
  end

  assign rd_key_o   = key_w[{1'b0, rd_idx_i}];
  assign rd_owner_o = owner_w[{1'b0, rd_idx_i}];

endmodule

FILE: hw/rtl/outstanding_request_tracker.sv
// sequencer steps after accept: match, find, dispatch; a request not already held by the
// same supplier inserts, forgetting the entry first when another supplier held the key;
// forget request forgets a found entry; a live supplier's check runs the check steps and
// forget supplier drops its entries one per pass; one item in flight, output stalls hold
// off input. reset: all entries invalid, supplier state and counts zero, spacing 600 s,
// stall timeout 2 s; no clearing pass
module outstanding_request_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [orte_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          op_i,
  input  logic [3:0]                          peer_slot_i,
  input  logic [63:0]                         block_key_i,
  input  logic [62:0]                         now_us_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [3:0]                          owner_peer_o,
  output logic                                newly_marked_o,
  output logic                                stalled_o,
  output logic                                download_timed_out_o,
  output logic [63:0]                         oldest_block_key_o,
  output logic [6:0]                          peer_in_flight_o,
  output logic [6:0]                          total_in_flight_o
);

  localparam int NP = orte_pkg::PEER_SLOTS;

  // configuration
  logic [orte_pkg::SPACE_W-1:0] spacing_q;
  logic [orte_pkg::STALL_W-1:0] stall_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q  <= orte_pkg::SPACE_W'(600);
      stall_to_q <= orte_pkg::STALL_W'(2000000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        orte_pkg::CFG_SPACING: spacing_q  <= cfg_data_i[orte_pkg::SPACE_W-1:0];
        orte_pkg::CFG_STALL:   stall_to_q <= cfg_data_i[orte_pkg::STALL_W-1:0];
        default: ;
      endcase
    end
  end

  orte_pkg::state_e state_q, state_d;

  // latched item
  orte_pkg::op_e                op_q;
  logic [orte_pkg::PEER_W-1:0]  peer_q;
  logic [orte_pkg::KEY_W-1:0]   key_q;
  logic [orte_pkg::TIME_W-1:0]  now_q;

  // search results
  logic [orte_pkg::TABLE_ENTRIES-1:0] vec_q, vec_d;
  logic                               e_found_q, e_found_d;
  logic [orte_pkg::IDX_W-1:0]         e_idx_q, e_idx_d;
  logic [orte_pkg::PEER_W-1:0]        e_owner_q, e_owner_d;
  logic                               front_found_q, front_found_d;
  logic [orte_pkg::KEY_W-1:0]         front_key_q, front_key_d;
  logic [orte_pkg::MUL1_W-1:0]        prod1_q, prod1_d;
  logic [orte_pkg::DL_W:0]            dlp1_q, dlp1_d;
  logic [orte_pkg::MUL2_W-1:0]        prod2_q, prod2_d;

  // result being built
  logic [1:0]                  res_status_q, res_status_d;
  logic [orte_pkg::PEER_W-1:0] res_owner_q, res_owner_d;
  logic                        res_marked_q, res_marked_d;
  logic                        res_stalled_q, res_stalled_d;
  logic                        res_timed_q, res_timed_d;
  logic [orte_pkg::KEY_W-1:0]  res_oldest_q, res_oldest_d;

  // per supplier state
  logic                        present_q     [NP];
  logic                        present_d     [NP];
  logic [orte_pkg::CNT_W-1:0]  count_q       [NP];
  logic [orte_pkg::CNT_W-1:0]  count_d       [NP];
  logic [orte_pkg::TIME_W-1:0] dl_since_q    [NP];
  logic [orte_pkg::TIME_W-1:0] dl_since_d    [NP];
  logic                        stall_v_q     [NP];
  logic                        stall_v_d     [NP];
  logic [orte_pkg::TIME_W-1:0] stall_since_q [NP];
  logic [orte_pkg::TIME_W-1:0] stall_since_d [NP];
  logic [orte_pkg::DL_W-1:0]   dl_peers_q, dl_peers_d;
  logic [orte_pkg::CNT_W-1:0]  total_q, total_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  o_status_q;
  logic [orte_pkg::PEER_W-1:0] o_owner_q;
  logic                        o_marked_q;
  logic                        o_stalled_q;
  logic                        o_timed_q;
  logic [orte_pkg::KEY_W-1:0]  o_oldest_q;
  logic [orte_pkg::CNT_W-1:0]  o_peer_cnt_q;
  logic [orte_pkg::CNT_W-1:0]  o_total_q;

  logic accept_in;
  logic out_free;
  logic load_out;

  assign in_stall_o = (state_q != orte_pkg::S_IDLE);
  assign accept_in  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == orte_pkg::S_DONE) && out_free;

  // supplier slot addressed: the owner of the found entry while forgetting it
  logic [orte_pkg::PEER_W-1:0] pidx;
  logic                        p_ok;
  logic                        p_live;
  logic                        peer_ok;
  logic [orte_pkg::CNT_W-1:0]  cur_cnt;

  assign pidx    = (state_q == orte_pkg::S_FGT1 || state_q == orte_pkg::S_FGT2)
                   ? e_owner_q : peer_q;
  assign p_ok    = (32'(pidx) < NP);
  assign p_live  = p_ok && present_q[pidx];
  assign peer_ok = (32'(peer_q) < NP);
  assign cur_cnt = count_q[pidx];

  // cell row
  orte_pkg::chain_ctl_t               ctl;
  logic [orte_pkg::TABLE_ENTRIES-1:0] key_hit;
  logic [orte_pkg::TABLE_ENTRIES-1:0] own_hit;
  logic [orte_pkg::KEY_W-1:0]         rd_key;
  logic [orte_pkg::PEER_W-1:0]        rd_owner;
  orte_pkg::pick_t                    pick;

  orte_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_idx_i   (pick.idx),
    .key_hit_o  (key_hit),
    .own_hit_o  (own_hit),
    .rd_key_o   (rd_key),
    .rd_owner_o (rd_owner)
  );

  orte_pick u_pick (
    .vec_i  (vec_q),
    .pick_o (pick)
  );

  // time comparisons, one bit wider than the stamps
  logic stall_old;
  logic dl_late;

  assign stall_old = ({1'b0, stall_since_q[pidx]} + 64'(stall_to_q)) < {1'b0, now_q};
  assign dl_late   = {1'b0, now_q} > ({1'b0, dl_since_q[pidx]} + 64'(prod2_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      orte_pkg::S_IDLE:  if (accept_in) state_d = orte_pkg::S_MATCH;
      orte_pkg::S_MATCH: state_d = orte_pkg::S_FIND;
      orte_pkg::S_FIND:  state_d = orte_pkg::S_DISP;
      orte_pkg::S_DISP: begin
        unique case (op_q)
          orte_pkg::OP_REQUEST: begin
            priority if (!peer_ok)                          state_d = orte_pkg::S_DONE;
            else if (e_found_q && e_owner_q == peer_q)      state_d = orte_pkg::S_DONE;
            else if (e_found_q)                             state_d = orte_pkg::S_FGT1;
            else                                            state_d = orte_pkg::S_INS;
          end
          orte_pkg::OP_FORGET_REQ:
            state_d = e_found_q ? orte_pkg::S_FGT1 : orte_pkg::S_DONE;
          orte_pkg::OP_FORGET_SUP:
            state_d = p_live ? orte_pkg::S_SUP1 : orte_pkg::S_DONE;
          orte_pkg::OP_CHECK:
            state_d = p_live ? orte_pkg::S_CHK1 : orte_pkg::S_DONE;
          default: state_d = orte_pkg::S_DONE;
        endcase
      end
      orte_pkg::S_FGT1: state_d = orte_pkg::S_FGT2;
      orte_pkg::S_FGT2:
        state_d = (op_q == orte_pkg::OP_REQUEST) ? orte_pkg::S_INS : orte_pkg::S_DONE;
      orte_pkg::S_INS:  state_d = orte_pkg::S_DONE;
      orte_pkg::S_SUP1: state_d = orte_pkg::S_SUP2;
      orte_pkg::S_SUP2: state_d = pick.found ? orte_pkg::S_SUP1 : orte_pkg::S_DONE;
      orte_pkg::S_CHK1: state_d = orte_pkg::S_CHK2;
      orte_pkg::S_CHK2: state_d = orte_pkg::S_CHK3;
      orte_pkg::S_CHK3: state_d = orte_pkg::S_DONE;
      orte_pkg::S_DONE: if (out_free) state_d = orte_pkg::S_IDLE;
      default: state_d = orte_pkg::S_IDLE;
    endcase
  end

  // datapath and state updates
  always_comb begin
    vec_d         = vec_q;
    e_found_d     = e_found_q;
    e_idx_d       = e_idx_q;
    e_owner_d     = e_owner_q;
    front_found_d = front_found_q;
    front_key_d   = front_key_q;
    prod1_d       = prod1_q;
    dlp1_d        = dlp1_q;
    prod2_d       = prod2_q;
    res_status_d  = res_status_q;
    res_owner_d   = res_owner_q;
    res_marked_d  = res_marked_q;
    res_stalled_d = res_stalled_q;
    res_timed_d   = res_timed_q;
    res_oldest_d  = res_oldest_q;
    present_d     = present_q;
    count_d       = count_q;
    dl_since_d    = dl_since_q;
    stall_v_d     = stall_v_q;
    stall_since_d = stall_since_q;
    dl_peers_d    = dl_peers_q;
    total_d       = total_q;

    ctl           = '0;
    ctl.cmp_key   = key_q;
    ctl.cmp_owner = pidx;
    ctl.ins_key   = key_q;
    ctl.ins_owner = peer_q;
    ctl.ins_idx   = total_q[orte_pkg::IDX_W-1:0];

    unique case (state_q)
      orte_pkg::S_IDLE: begin
        res_status_d  = orte_pkg::ST_NOT_FOUND;
        res_owner_d   = '0;
        res_marked_d  = 1'b0;
        res_stalled_d = 1'b0;
        res_timed_d   = 1'b0;
        res_oldest_d  = '0;
      end
      orte_pkg::S_MATCH: vec_d = key_hit;
      orte_pkg::S_FIND: begin
        e_found_d = pick.found;
        e_idx_d   = pick.idx;
        e_owner_d = rd_owner;
      end
      orte_pkg::S_DISP: begin
        unique case (op_q)
          orte_pkg::OP_REQUEST: begin
            if (peer_ok && e_found_q && e_owner_q == peer_q) begin
              res_status_d = orte_pkg::ST_SAME;
              res_owner_d  = peer_q;
            end
          end
          orte_pkg::OP_MARK_STALL: begin
            if (p_live) begin
              res_status_d = orte_pkg::ST_OK;
              if (!stall_v_q[pidx]) begin
                stall_v_d[pidx]     = 1'b1;
                stall_since_d[pidx] = now_q;
                res_marked_d        = 1'b1;
              end
            end
          end
          orte_pkg::OP_LOOKUP: begin
            if (e_found_q) begin
              res_status_d = orte_pkg::ST_OK;
              res_owner_d  = e_owner_q;
            end
          end
          default: ;
        endcase
      end
      orte_pkg::S_FGT1: vec_d = own_hit;
      orte_pkg::S_FGT2: begin
        if (p_live) begin
          // oldest entry of the owner is the lowest cell it holds
          if (pick.found && pick.idx == e_idx_q && now_q > dl_since_q[pidx]) begin
            dl_since_d[pidx] = now_q;
          end
          ctl.del     = 1'b1;
          ctl.del_idx = e_idx_q;
          if (total_q != '0) total_d = total_q - 1'b1;
          if (cur_cnt != '0) begin
            count_d[pidx] = cur_cnt - 1'b1;
            if (cur_cnt == orte_pkg::CNT_W'(1) && dl_peers_q != '0) begin
              dl_peers_d = dl_peers_q - 1'b1;
            end
          end
          stall_v_d[pidx] = 1'b0;
          if (op_q == orte_pkg::OP_FORGET_REQ) begin
            res_status_d = orte_pkg::ST_OK;
            res_owner_d  = e_owner_q;
          end
        end
      end
      orte_pkg::S_INS: begin
        if (32'(total_q) >= orte_pkg::TABLE_ENTRIES) begin
          res_status_d = orte_pkg::ST_FULL;
        end else begin
          // entries stay packed in arrival order, so the tail is the free cell
          ctl.ins         = 1'b1;
          present_d[pidx] = 1'b1;
          count_d[pidx]   = cur_cnt + 1'b1;
          total_d         = total_q + 1'b1;
          if (cur_cnt == '0) begin
            dl_since_d[pidx] = now_q;
            dl_peers_d       = dl_peers_q + 1'b1;
          end
          res_status_d = orte_pkg::ST_OK;
          res_owner_d  = peer_q;
        end
      end
      orte_pkg::S_SUP1: vec_d = own_hit;
      orte_pkg::S_SUP2: begin
        if (pick.found) begin
          ctl.del     = 1'b1;
          ctl.del_idx = pick.idx;
          if (total_q != '0) total_d = total_q - 1'b1;
        end else begin
          if (cur_cnt != '0 && dl_peers_q != '0) dl_peers_d = dl_peers_q - 1'b1;
          present_d[pidx]     = 1'b0;
          count_d[pidx]       = '0;
          dl_since_d[pidx]    = '0;
          stall_v_d[pidx]     = 1'b0;
          stall_since_d[pidx] = '0;
          res_status_d        = orte_pkg::ST_OK;
        end
      end
      orte_pkg::S_CHK1: begin
        vec_d   = own_hit;
        prod1_d = orte_pkg::MUL1_W'(spacing_q) * orte_pkg::MUL1_W'(orte_pkg::HALF_SEC_US);
        // no downloading peers counts as one
        dlp1_d  = (dl_peers_q == '0) ? (orte_pkg::DL_W+1)'(2)
                                     : {1'b0, dl_peers_q} + 1'b1;
      end
      orte_pkg::S_CHK2: begin
        prod2_d       = orte_pkg::MUL2_W'(prod1_q) * orte_pkg::MUL2_W'(dlp1_q);
        front_found_d = pick.found;
        front_key_d   = rd_key;
      end
      orte_pkg::S_CHK3: begin
        res_status_d  = orte_pkg::ST_OK;
        res_stalled_d = stall_v_q[pidx] && stall_old;
        if (cur_cnt != '0 && dl_late && front_found_q) begin
          res_timed_d  = 1'b1;
          res_oldest_d = front_key_q;
        end
      end
      orte_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= orte_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      dl_peers_q  <= '0;
      total_q     <= '0;
      for (int i = 0; i < NP; i++) begin
        present_q[i]     <= 1'b0;
        count_q[i]       <= '0;
        dl_since_q[i]    <= '0;
        stall_v_q[i]     <= 1'b0;
        stall_since_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      dl_peers_q    <= dl_peers_d;
      total_q       <= total_d;
      present_q     <= present_d;
      count_q       <= count_d;
      dl_since_q    <= dl_since_d;
      stall_v_q     <= stall_v_d;
      stall_since_q <= stall_since_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q   <= orte_pkg::op_e'(op_i);
      peer_q <= peer_slot_i;
      key_q  <= block_key_i;
      now_q  <= now_us_i;
    end
    vec_q         <= vec_d;
    e_found_q     <= e_found_d;
    e_idx_q       <= e_idx_d;
    e_owner_q     <= e_owner_d;
    front_found_q <= front_found_d;
    front_key_q   <= front_key_d;
    prod1_q       <= prod1_d;
    dlp1_q        <= dlp1_d;
    prod2_q       <= prod2_d;
    res_status_q  <= res_status_d;
    res_owner_q   <= res_owner_d;
    res_marked_q  <= res_marked_d;
    res_stalled_q <= res_stalled_d;
    res_timed_q   <= res_timed_d;
    res_oldest_q  <= res_oldest_d;
    if (load_out) begin
      o_status_q   <= res_status_q;
      o_owner_q    <= res_owner_q;
      o_marked_q   <= res_marked_q;
      o_stalled_q  <= res_stalled_q;
      o_timed_q    <= res_timed_q;
      o_oldest_q   <= res_oldest_q;
      o_peer_cnt_q <= peer_ok ? count_q[pidx] : '0;
      o_total_q    <= total_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = o_status_q;
  assign owner_peer_o         = o_owner_q;
  assign newly_marked_o       = o_marked_q;
  assign stalled_o            = o_stalled_q;
  assign download_timed_out_o = o_timed_q;
  assign oldest_block_key_o   = o_oldest_q;
  assign peer_in_flight_o     = 7'(o_peer_cnt_q);
  assign total_in_flight_o    = 7'(o_total_q);

endmodule

FILE: tb/orte_checker.sv
`timescale 1ns / 100ps

module orte_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [orte_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [2:0]                  op_i,
  input  logic [3:0]                  peer_slot_i,
  input  logic [63:0]                 block_key_i,
  input  logic [62:0]                 now_us_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  status_i,
  input  logic [3:0]                  owner_peer_i,
  input  logic                        newly_marked_i,
  input  logic                        stalled_i,
  input  logic                        download_timed_out_i,
  input  logic [63:0]                 oldest_block_key_i,
  input  logic [6:0]                  peer_in_flight_i,
  input  logic [6:0]                  total_in_flight_i,
  output int                          errors_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  owner;
    logic        marked;
    logic        stalled;
    logic        timed;
    logic [63:0] oldest;
    logic [6:0]  peer_cnt;
    logic [6:0]  total;
  } verdict_t;

  verdict_t verdicts_q[$];

  logic [11:0]  spacing;
  logic [25:0]  stall_to;
  logic         ent_v[orte_pkg::TABLE_ENTRIES];
  logic [63:0]  ent_key[orte_pkg::TABLE_ENTRIES];
  logic [3:0]   ent_own[orte_pkg::TABLE_ENTRIES];
  logic [31:0]  ent_ord[orte_pkg::TABLE_ENTRIES];
  logic [31:0]  ord_ctr;
  logic         sup_here[orte_pkg::PEER_SLOTS];
  logic [6:0]   sup_cnt[orte_pkg::PEER_SLOTS];
  logic [63:0]  sup_since[orte_pkg::PEER_SLOTS];
  logic         sup_mark[orte_pkg::PEER_SLOTS];
  logic [63:0]  sup_mark_at[orte_pkg::PEER_SLOTS];
  logic [4:0]   busy_sups;
  logic [6:0]   live;

  assign pending_o = verdicts_q.size();

  function automatic int key_slot(logic [63:0] k);
    for (int i = 0; i < orte_pkg::TABLE_ENTRIES; i++)
      if (ent_v[i] && ent_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_slot(logic [3:0] p);
    int best;
    logic [31:0] age, best_age;
    best = -1;
    best_age = 0;
    for (int i = 0; i < orte_pkg::TABLE_ENTRIES; i++)
      if (ent_v[i] && ent_own[i] == p) begin
        age = ord_ctr - ent_ord[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    return best;
  endfunction

  function automatic bit drop_key(logic [63:0] k, logic [63:0] now, output logic [3:0] own);
    int e;
    logic [3:0] p;
    e = key_slot(k);
    own = 0;
    if (e < 0) return 0;
    p = ent_own[e];
    own = p;
    if (!sup_here[p]) return 0;
    if (oldest_slot(p) == e && now > sup_since[p]) sup_since[p] = now;
    ent_v[e] = 0;
    if (live > 0) live--;
    if (sup_cnt[p] > 0) begin
      sup_cnt[p]--;
      if (sup_cnt[p] == 0 && busy_sups > 0) busy_sups--;
    end
    sup_mark[p] = 0;
    return 1;
  endfunction

  function automatic verdict_t track(logic [2:0] op, logic [3:0] p, logic [63:0] k,
                                     logic [63:0] now);
    verdict_t v;
    int e;
    logic [3:0] o;
    logic [63:0] dl, lim;
    v = '0;
    v.status = orte_pkg::ST_NOT_FOUND;
    case (op)
      orte_pkg::OP_REQUEST: begin
        e = key_slot(k);
        if (e >= 0 && ent_own[e] == p) begin
          v.status = orte_pkg::ST_SAME;
          v.owner = p;
        end else begin
          if (e >= 0) void'(drop_key(k, now, o));
          e = -1;
          for (int i = 0; i < orte_pkg::TABLE_ENTRIES; i++)
            if (e < 0 && !ent_v[i]) e = i;
          if (e < 0) v.status = orte_pkg::ST_FULL;
          else begin
            sup_here[p] = 1;
            ent_v[e] = 1;
            ent_key[e] = k;
            ent_own[e] = p;
            ent_ord[e] = ord_ctr;
            ord_ctr++;
            live++;
            sup_cnt[p]++;
            if (sup_cnt[p] == 1) begin
              sup_since[p] = now;
              busy_sups++;
            end
            v.status = orte_pkg::ST_OK;
            v.owner = p;
          end
        end
      end
      orte_pkg::OP_FORGET_REQ: if (drop_key(k, now, o)) begin
        v.status = orte_pkg::ST_OK;
        v.owner = o;
      end
      orte_pkg::OP_FORGET_SUP: if (sup_here[p]) begin
        for (int i = 0; i < orte_pkg::TABLE_ENTRIES; i++)
          if (ent_v[i] && ent_own[i] == p) begin
            ent_v[i] = 0;
            if (live > 0) live--;
          end
        if (sup_cnt[p] > 0 && busy_sups > 0) busy_sups--;
        sup_here[p] = 0;
        sup_cnt[p] = 0;
        sup_since[p] = 0;
        sup_mark[p] = 0;
        sup_mark_at[p] = 0;
        v.status = orte_pkg::ST_OK;
      end
      orte_pkg::OP_MARK_STALL: if (sup_here[p]) begin
        if (!sup_mark[p]) begin
          sup_mark[p] = 1;
          sup_mark_at[p] = now;
          v.marked = 1;
        end
        v.status = orte_pkg::ST_OK;
      end
      orte_pkg::OP_CHECK: if (sup_here[p]) begin
        v.status = orte_pkg::ST_OK;
        if (sup_mark[p] && sup_mark_at[p] + 64'(stall_to) < now) v.stalled = 1;
        if (sup_cnt[p] > 0) begin
          dl = busy_sups > 0 ? 64'(busy_sups) : 64'd1;
          lim = 64'(spacing) * 64'd500000 * (dl + 64'd1);
          if (now > sup_since[p] + lim) begin
            e = oldest_slot(p);
            if (e >= 0) begin
              v.timed = 1;
              v.oldest = ent_key[e];
            end
          end
        end
      end
      orte_pkg::OP_LOOKUP: begin
        e = key_slot(k);
        if (e >= 0) begin
          v.status = orte_pkg::ST_OK;
          v.owner = ent_own[e];
        end
      end
      default: ;
    endcase
    v.peer_cnt = sup_cnt[p];
    v.total = live;
    return v;
  endfunction

  verdict_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing = 12'd600;
      stall_to = 26'd2000000;
      for (int i = 0; i < orte_pkg::TABLE_ENTRIES; i++) ent_v[i] = 0;
      for (int i = 0; i < orte_pkg::PEER_SLOTS; i++) begin
        sup_here[i] = 0;
        sup_cnt[i] = 0;
        sup_since[i] = 0;
        sup_mark[i] = 0;
        sup_mark_at[i] = 0;
      end
      ord_ctr = 0;
      busy_sups = 0;
      live = 0;
      errors_o = 0;
      verdicts_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == orte_pkg::CFG_SPACING) spacing = cfg_data_i[11:0];
        else stall_to = cfg_data_i[25:0];
      end
      // result compared against the oldest waiting verdict
      if (out_valid_i && !out_stall_i) begin
        got = '{status_i, owner_peer_i, newly_marked_i, stalled_i, download_timed_out_i,
                oldest_block_key_i, peer_in_flight_i, total_in_flight_i};
        if (verdicts_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result %p", got);
        end else begin
          want = verdicts_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      // new verdict goes to the tail of the queue
      if (in_valid_i && !in_stall_i)
        verdicts_q.insert(verdicts_q.size(),
                          track(op_i, peer_slot_i, block_key_i, {1'b0, now_us_i}));
    end
  end

endmodule

FILE: tb/tb_outstanding_request_tracker.sv
`timescale 1ns / 100ps

module tb_outstanding_request_tracker;

  logic                       clk_i, rst_ni;
  logic                       cfg_we, cfg_idx;
  logic [orte_pkg::CFG_W-1:0] cfg_data;
  logic                       in_valid, in_stall;
  logic [2:0]                 op;
  logic [3:0]                 peer_slot;
  logic [63:0]                block_key;
  logic [62:0]                now_us;
  logic                       out_valid, out_stall;
  logic [1:0]                 status;
  logic [3:0]                 owner_peer;
  logic                       newly_marked, stalled, timed_out;
  logic [63:0]                oldest_key;
  logic [6:0]                 peer_in_flight, total_in_flight;
  int                         errors, waiting;
  int                         quiet_cycles;
  bit                         calm;       // no idling on either side while set
  logic [62:0]                clock_us;   // running time fed to the block
  logic [63:0]                key_pool[24];

  outstanding_request_tracker DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .peer_slot_i(peer_slot), .block_key_i(block_key), .now_us_i(now_us),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .owner_peer_o(owner_peer), .newly_marked_o(newly_marked),
    .stalled_o(stalled), .download_timed_out_o(timed_out),
    .oldest_block_key_o(oldest_key), .peer_in_flight_o(peer_in_flight),
    .total_in_flight_o(total_in_flight)
  );

  orte_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .peer_slot_i(peer_slot), .block_key_i(block_key), .now_us_i(now_us),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .owner_peer_i(owner_peer), .newly_marked_i(newly_marked),
    .stalled_i(stalled), .download_timed_out_i(timed_out),
    .oldest_block_key_i(oldest_key), .peer_in_flight_i(peer_in_flight),
    .total_in_flight_i(total_in_flight),
    .errors_o(errors), .pending_o(waiting)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver stalls about 18 percent of cycles unless calm
  always @(posedge clk_i)
    out_stall <= !calm && ($urandom_range(99) < 18);

  // watchdog on cycles with no accepted item or result
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_outstanding_request_tracker failed");
      $finish;
    end
  end

  // one item, with optional idle cycles ahead of it; valid stays up until the caller moves on
  task automatic send(logic [2:0] o, logic [3:0] p, logic [63:0] k, logic [62:0] t);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid  <= 1;
    op        <= o;
    peer_slot <= p;
    block_key <= k;
    now_us    <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // write enable stays up until the caller drops it
  task automatic write_reg(logic idx, logic [orte_pkg::CFG_W-1:0] val);
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  // random item, mostly on a small key pool so keys collide and get forgotten
  task automatic random_item();
    logic [2:0] o;
    logic [63:0] k;
    int r;
    r = $urandom_range(99);
    if (r < 40) o = orte_pkg::OP_REQUEST;
    else if (r < 55) o = orte_pkg::OP_FORGET_REQ;
    else if (r < 62) o = orte_pkg::OP_FORGET_SUP;
    else if (r < 72) o = orte_pkg::OP_MARK_STALL;
    else if (r < 87) o = orte_pkg::OP_CHECK;
    else if (r < 97) o = orte_pkg::OP_LOOKUP;
    else o = 3'($urandom_range(7));
    k = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(23)];
    // time mostly advances, sometimes in big leaps, rarely jumps anywhere
    r = $urandom_range(99);
    if (r < 70) clock_us = clock_us + 63'($urandom_range(400000));
    else if (r < 95) clock_us = clock_us + 63'($urandom) * 63'd4;
    else clock_us = 63'({$urandom, $urandom});
    send(o, 4'($urandom_range(15)), k, clock_us);
  endtask

  initial begin
    rst_ni   = 0;
    cfg_we   = 0;
    cfg_idx  = orte_pkg::CFG_SPACING;
    cfg_data = '0;
    in_valid = 0;
    op = '0; peer_slot = '0; block_key = '0; now_us = '0;
    out_stall = 0;
    quiet_cycles = 0;
    calm = 0;
    clock_us = 0;
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: unknown supplier, requests, duplicates, steal, stall, timeout
    send(orte_pkg::OP_CHECK, 4'd3, 64'd0, 63'd0);
    send(orte_pkg::OP_MARK_STALL, 4'd3, 64'd0, 63'd0);
    send(orte_pkg::OP_FORGET_SUP, 4'd15, 64'd0, 63'd0);
    send(orte_pkg::OP_FORGET_REQ, 4'd0, key_pool[1], 63'd0);
    send(orte_pkg::OP_REQUEST, 4'd0, key_pool[0], 63'd0);
    send(orte_pkg::OP_REQUEST, 4'd0, key_pool[0], 63'd5);
    send(orte_pkg::OP_REQUEST, 4'd15, key_pool[1], 63'd10);
    send(orte_pkg::OP_REQUEST, 4'd15, key_pool[2], 63'd20);
    send(orte_pkg::OP_REQUEST, 4'd7, key_pool[1], 63'd30);
    send(orte_pkg::OP_LOOKUP, 4'd0, key_pool[1], 63'd30);
    send(orte_pkg::OP_MARK_STALL, 4'd15, 64'd0, 63'd40);
    send(orte_pkg::OP_MARK_STALL, 4'd15, 64'd0, 63'd50);
    send(orte_pkg::OP_CHECK, 4'd15, 64'd0, 63'd2000041);
    send(orte_pkg::OP_CHECK, 4'd15, 64'd0, 63'd1800000021);
    send(orte_pkg::OP_CHECK, 4'd0, 64'd0, '1);
    send(orte_pkg::OP_FORGET_REQ, 4'd0, key_pool[0], '1);
    send(orte_pkg::OP_LOOKUP, 4'd0, key_pool[5], 63'd0);
    send(3'd6, 4'd2, 64'd0, 63'd0);
    send(3'd7, 4'd2, '1, '1);
    send(orte_pkg::OP_FORGET_SUP, 4'd15, 64'd0, 63'd60);
    // fill the table, then overflow it
    for (int i = 0; i < 65; i++)
      send(orte_pkg::OP_REQUEST, 4'(i % 3), {32'hF11, 32'(i)}, 63'd100);
    for (int i = 0; i < 3; i++) send(orte_pkg::OP_FORGET_SUP, 4'(i), 64'd0, 63'd200);
    drain();

    // sweep register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(orte_pkg::CFG_SPACING, orte_pkg::CFG_W'(1));
          write_reg(orte_pkg::CFG_STALL, orte_pkg::CFG_W'(0));
        end
        1: begin
          write_reg(orte_pkg::CFG_SPACING, orte_pkg::CFG_W'(3600));
          write_reg(orte_pkg::CFG_STALL, orte_pkg::CFG_W'(60000000));
        end
        2: begin
          write_reg(orte_pkg::CFG_SPACING, orte_pkg::CFG_W'(4095));
          write_reg(orte_pkg::CFG_STALL, '1);
        end
        default: begin
          write_reg(orte_pkg::CFG_SPACING, orte_pkg::CFG_W'($urandom_range(1, 3600)));
          write_reg(orte_pkg::CFG_STALL, orte_pkg::CFG_W'($urandom_range(0, 60000000)));
        end
      endcase
      cfg_we <= 0;
      calm = (ph == 3);
      for (int n = 0; n < 280; n++) begin
        random_item();
        // sender holds back until every result is in
        if (n == 140) begin
          in_valid <= 0;
          @(posedge clk_i);
          while (waiting != 0) @(posedge clk_i);
        end
      end
      for (int i = 0; i < 16 && ph == 5; i++)
        send(orte_pkg::OP_FORGET_SUP, 4'(i), 64'd0, clock_us);
      drain();
    end
    calm = 0;

    if (errors == 0) $display("tb_outstanding_request_tracker passed");
    else $display("tb_outstanding_request_tracker failed");
    $finish;
  end

endmodule
